### hdl/skl_pkg.sv
// Package with the shared types and constants of the sequential key list.
package skl_pkg;

  localparam int unsigned Depth   = 64;
  localparam int unsigned KeyW    = 32;
  localparam int unsigned OpW     = 2;
  localparam int unsigned StatusW = 3;
  localparam int unsigned PosW    = 6;
  localparam int unsigned FillW   = 7;
  localparam int unsigned CapW    = 7;

  localparam logic [CapW-1:0] CapReset = 7'd64;

  typedef enum logic [OpW-1:0] {
    OpSearch = 2'd0,
    OpInsert = 2'd1,
    OpDelete = 2'd2
  } skl_op_e;

  typedef enum logic [StatusW-1:0] {
    StFound     = 3'd0,
    StNotFound  = 3'd1,
    StInserted  = 3'd2,
    StDuplicate = 3'd3,
    StFull      = 3'd4,
    StRemoved   = 3'd5
  } skl_status_e;

  typedef enum logic [1:0] {
    SIdle,
    SScan,
    SShift,
    SDone
  } skl_state_e;

  typedef struct packed {
    skl_status_e       status;
    logic [PosW-1:0]   position;
    logic [FillW-1:0]  fill;
  } skl_rsp_t;

endpackage

### hdl/skl_if.sv
// Channel interfaces of the sequential key list: request, response and configuration.
interface skl_req_if;
  logic                            valid;
  logic                            ready;
  logic [skl_pkg::OpW-1:0]         op;
  logic signed [skl_pkg::KeyW-1:0] key;

  modport source (output valid, output op, output key, input ready);
  modport sink (input valid, input op, input key, output ready);
endinterface

interface skl_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [skl_pkg::StatusW-1:0]  status;
  logic [skl_pkg::PosW-1:0]     position;
  logic [skl_pkg::FillW-1:0]    fill;

  modport source (output valid, output status, output position, output fill, input ready);
  modport sink (input valid, input status, input position, input fill, output ready);
endinterface

interface skl_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [skl_pkg::CapW-1:0]   capacity;

  modport source (output valid, output capacity, input ready);
  modport sink (input valid, input capacity, output ready);
endinterface

### hdl/sequential_key_list.sv
// Top level of the sequential key list: capacity register, sequencer and result register.
//
// The block keeps a compact table of distinct signed 32-bit keys with a fill count.
// Requests arrive on req_i (op and key); each one yields exactly one item on rsp_o
// carrying status, position and the fill count after the request.
// The capacity register is written through cfg_i, which is always ready; it should
// only be written while no request is in work.
// Each request scans the table through the single read port of the key memory and its
// one compare: a search or an insert stops at a matching key; a miss scans all entries
// and an insert of a new key then appends it; an insert into a full table skips the
// scan; a delete of a found key then moves each later entry down by one.
// The sequencer takes one request at a time and drops req_i.ready until its result
// has moved into the output register; a new request waits until the last is done.
// A result may wait in that register while the next request is already being searched.
// When the receiver stalls, rsp_o holds its item and the sequencer stops at the
// end of its next request until the register frees up.
// Reset clears the fill count to zero and sets the capacity to 64; key storage is
// not cleared, since entries at or above the fill count are never used.
module sequential_key_list #(
  parameter int unsigned DEPTH = skl_pkg::Depth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  skl_cfg_if.sink    cfg_i,
  skl_req_if.sink    req_i,
  skl_rsp_if.source  rsp_o
);

  logic [skl_pkg::CapW-1:0] capacity_q;
  logic                     rsp_vld_q;
  skl_pkg::skl_rsp_t        rsp_q;
  logic                     res_vld;
  skl_pkg::skl_rsp_t        res;
  logic                     res_rdy;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= skl_pkg::CapReset;
    end else if (cfg_i.valid) begin
      capacity_q <= cfg_i.capacity;
    end
  end

  skl_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req       (req_i),
    .capacity_i(capacity_q),
    .res_vld_o (res_vld),
    .res_o     (res),
    .res_rdy_i (res_rdy)
  );

  assign res_rdy = !rsp_vld_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_vld_q <= 1'b0;
    end else if (res_rdy) begin
      rsp_vld_q <= res_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_rdy && res_vld) begin
      rsp_q <= res;
    end
  end

  assign rsp_o.valid    = rsp_vld_q;
  assign rsp_o.status   = rsp_q.status;
  assign rsp_o.position = rsp_q.position;
  assign rsp_o.fill     = rsp_q.fill;

endmodule

### hdl/skl_mem.sv
// Key storage: one write port and one read port with registered read data.
module skl_mem #(
  parameter int unsigned DEPTH = skl_pkg::Depth,
  parameter int unsigned WIDTH = skl_pkg::KeyW,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] ram_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      ram_q[waddr_i] <= wdata_i;
    end
    rdata_q <= ram_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/skl_ctrl.sv
// Sequencer that scans, appends and compacts the key table with one shared compare.
module skl_ctrl #(
  parameter int unsigned DEPTH = skl_pkg::Depth,
  localparam int unsigned AW = $clog2(DEPTH),
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  skl_req_if.sink                   req,
  input  logic [skl_pkg::CapW-1:0]  capacity_i,
  output logic                      res_vld_o,
  output skl_pkg::skl_rsp_t         res_o,
  input  logic                      res_rdy_i
);

  localparam int unsigned KW   = skl_pkg::KeyW;
  localparam int unsigned PW   = skl_pkg::PosW;
  localparam int unsigned FW   = skl_pkg::FillW;
  localparam int unsigned CmpW = (CW > skl_pkg::CapW) ? CW : skl_pkg::CapW;

  skl_pkg::skl_state_e state_q, state_d;
  skl_pkg::skl_op_e    op_q, op_d;
  logic [KW-1:0]       key_q, key_d;
  logic [CW-1:0]       idx_q, idx_d;
  logic                cmp_vld_q, cmp_vld_d;
  logic [AW-1:0]       cmp_idx_q, cmp_idx_d;
  logic [AW-1:0]       where_q, where_d;
  logic [CW-1:0]       count_q, count_d;
  skl_pkg::skl_rsp_t   res_q, res_d;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [KW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [KW-1:0] mem_rdata;
  logic          hit;
  logic          full;

  skl_mem #(
    .DEPTH(DEPTH),
    .WIDTH(KW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign hit  = cmp_vld_q && (mem_rdata == key_q);
  assign full = (CmpW'(count_q) >= CmpW'(capacity_i)) || (count_q >= CW'(DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= skl_pkg::SIdle;
      count_q   <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      cmp_vld_q <= cmp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    key_q     <= key_d;
    idx_q     <= idx_d;
    cmp_idx_q <= cmp_idx_d;
    where_q   <= where_d;
    res_q     <= res_d;
  end

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    key_d     = key_q;
    idx_d     = idx_q;
    cmp_vld_d = cmp_vld_q;
    cmp_idx_d = cmp_idx_q;
    where_d   = where_q;
    count_d   = count_q;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_waddr = cmp_idx_q - AW'(1);
    mem_wdata = mem_rdata;
    mem_raddr = idx_q[AW-1:0];
    req.ready = 1'b0;
    res_vld_o = 1'b0;

    unique case (state_q)
      skl_pkg::SIdle: begin
        req.ready = 1'b1;
        if (req.valid) begin
          op_d      = skl_pkg::skl_op_e'(req.op);
          key_d     = req.key;
          idx_d     = '0;
          cmp_vld_d = 1'b0;
          if (skl_pkg::skl_op_e'(req.op) == skl_pkg::OpInsert && full) begin
            res_d.status   = skl_pkg::StFull;
            res_d.position = '0;
            res_d.fill     = FW'(count_q);
            state_d        = skl_pkg::SDone;
          end else begin
            state_d = skl_pkg::SScan;
          end
        end
      end

      skl_pkg::SScan: begin
        if (hit) begin
          where_d   = cmp_idx_q;
          cmp_vld_d = 1'b0;
          case (op_q)
            skl_pkg::OpInsert: begin
              res_d.status   = skl_pkg::StDuplicate;
              res_d.position = '0;
              res_d.fill     = FW'(count_q);
              state_d        = skl_pkg::SDone;
            end
            skl_pkg::OpDelete: begin
              idx_d   = CW'(cmp_idx_q) + CW'(1);
              state_d = skl_pkg::SShift;
            end
            default: begin
              res_d.status   = skl_pkg::StFound;
              res_d.position = PW'(cmp_idx_q);
              res_d.fill     = FW'(count_q);
              state_d        = skl_pkg::SDone;
            end
          endcase
        end else if (idx_q < count_q) begin
          idx_d     = idx_q + CW'(1);
          cmp_vld_d = 1'b1;
          cmp_idx_d = idx_q[AW-1:0];
        end else begin
          cmp_vld_d = 1'b0;
          state_d   = skl_pkg::SDone;
          if (op_q == skl_pkg::OpInsert) begin
            mem_we         = 1'b1;
            mem_waddr      = count_q[AW-1:0];
            mem_wdata      = key_q;
            count_d        = count_q + CW'(1);
            res_d.status   = skl_pkg::StInserted;
            res_d.position = PW'(count_q);
            res_d.fill     = FW'(count_q + CW'(1));
          end else begin
            res_d.status   = skl_pkg::StNotFound;
            res_d.position = '0;
            res_d.fill     = FW'(count_q);
          end
        end
      end

      skl_pkg::SShift: begin
        mem_we = cmp_vld_q;
        if (idx_q < count_q) begin
          idx_d     = idx_q + CW'(1);
          cmp_vld_d = 1'b1;
          cmp_idx_d = idx_q[AW-1:0];
        end else begin
          cmp_vld_d      = 1'b0;
          count_d        = count_q - CW'(1);
          res_d.status   = skl_pkg::StRemoved;
          res_d.position = PW'(where_q);
          res_d.fill     = FW'(count_q - CW'(1));
          state_d        = skl_pkg::SDone;
        end
      end

      skl_pkg::SDone: begin
        res_vld_o = 1'b1;
        if (res_rdy_i) begin
          state_d = skl_pkg::SIdle;
        end
      end

      default: begin
        state_d = skl_pkg::SIdle;
      end
    endcase
  end

  assign res_o = res_q;

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("key count exceeds the table depth");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> (state_q == skl_pkg::SDone))
    else $error("key count changed outside the end of a request");

  a_shift_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == skl_pkg::SShift && cmp_vld_q) |-> (cmp_idx_q != '0))
    else $error("compaction would write below entry zero");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req.valid && req.ready) |=> !req.ready)
    else $error("a second item was accepted while one is in work");

endmodule
